// File: rtl/core/afd_pkg.sv
package afd_pkg;

    // Frame layout
    localparam int unsigned HEADER_BYTES = 6;
    localparam logic [7:0]  SYNC0        = 8'hAA;
    localparam logic [7:0]  SYNC1        = 8'h55;
    localparam logic [7:0]  ID_INFO      = 8'h12;
    localparam logic [7:0]  ID_ORIENT    = 8'h33;
    localparam logic [7:0]  ID_PARAM     = 8'h41;
    localparam logic [15:0] LEN_OVERHEAD = 16'd4;

    // Body offsets
    localparam logic [15:0] ORIENT_MAIN_END = 16'd24;  // yaw..mag words end here
    localparam logic [15:0] ORIENT_TEMP_HI  = 16'd33;  // temperature high byte
    localparam logic [15:0] PARAM_END       = 16'd4;
    localparam logic [15:0] INFO_BYTES      = 16'd48;
    localparam logic [15:0] INFO_LAST       = 16'd47;
    localparam logic [5:0]  TEMP_INDEX      = 6'd12;

    // Result kinds
    localparam logic [2:0] KIND_ORIENT  = 3'd0;
    localparam logic [2:0] KIND_INFO    = 3'd1;
    localparam logic [2:0] KIND_PARAM   = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Header error codes
    localparam logic [15:0] ERR_BAD_SYNC  = 16'd1;
    localparam logic [15:0] ERR_SHORT_LEN = 16'd2;

    // Config register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_SCALE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GYRO_SCALE  = 2'd1;
    localparam logic [31:0] SCALE_RESET = 32'h0100_0000;  // 1.0 in Q8.24

    // Scaling datapath
    localparam int unsigned VAL_W  = 40;
    localparam int unsigned PROD_W = 49;   // 17-bit magnitude x 32-bit multiplier
    localparam int unsigned Q_W    = 41;
    localparam logic [31:0] MUL_Q16     = 32'd65536;
    localparam logic [31:0] MUL_MAG     = 32'd655360;
    localparam logic [31:0] MUL_ONE     = 32'd1;
    localparam logic [31:0] RECIP_100   = 32'd42949672;   // floor(2^32/100)
    localparam logic [31:0] RECIP_10    = 32'd429496729;  // floor(2^32/10)
    localparam logic [6:0]  DIV_100     = 7'd100;
    localparam logic [6:0]  DIV_10      = 7'd10;
    localparam logic [7:0]  BIAS_100    = 8'd50;
    localparam logic [7:0]  BIAS_10     = 8'd5;
    localparam logic [7:0]  BIAS_SCALE  = 8'd128;
    localparam logic [Q_W-1:0] NEG_LIMIT = 41'h80_0000_0000;
    localparam logic [Q_W-1:0] POS_LIMIT = 41'h7F_FFFF_FFFF;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_BODY    = 2'd1,
        PH_HALT    = 2'd2,
        PH_BADSYNC = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        SC_RAW   = 3'd0,   // pass-through, unsigned
        SC_YAW   = 3'd1,   // unsigned, x65536/100
        SC_ATT   = 3'd2,   // signed, x65536/100
        SC_GYRO  = 3'd3,   // signed, x gyro_scale / 256
        SC_ACCEL = 3'd4,   // signed, x accel_scale / 256
        SC_MAG   = 3'd5,   // signed, x655360
        SC_TEMP  = 3'd6    // signed, x65536/10
    } t_scale;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  index;
        logic [15:0] word;
        t_scale      cls;
        logic        eom;
    } t_job;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] index;
        t_scale     cls;
        logic       eom;
        logic       neg;
    } t_meta;

    function automatic t_scale scale_of(input logic [3:0] idx);
        t_scale s;
        case (idx) inside
            4'd0:          s = SC_YAW;
            [4'd1:4'd2]:   s = SC_ATT;
            [4'd3:4'd5]:   s = SC_GYRO;
            [4'd6:4'd8]:   s = SC_ACCEL;
            [4'd9:4'd11]:  s = SC_MAG;
            default:       s = SC_TEMP;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/afd_front.sv
module afd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output afd_pkg::t_job o_job
);

    localparam logic [2:0] HDR_LAST = 3'(afd_pkg::HEADER_BYTES - 1);

    afd_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_hdr_pos, n_hdr_pos;
    logic [7:0]  r_msg_id, n_msg_id;
    logic [15:0] r_body_rem, n_body_rem;
    logic [15:0] r_body_pos, n_body_pos;
    logic [7:0]  r_low_hold, n_low_hold;
    logic        r_info_seen, n_info_seen;

    logic        accept;
    logic        hdr_last;
    logic        sync_bad;
    logic        body_last;
    logic        id_known;
    logic [15:0] word;

    assign o_stall   = i_full;
    assign accept    = i_valid && !i_full;
    assign hdr_last  = (r_hdr_pos == HDR_LAST);
    assign sync_bad  = ((r_hdr_pos == 3'd0) && (i_rx_byte != afd_pkg::SYNC0)) ||
                       ((r_hdr_pos == 3'd1) && (i_rx_byte != afd_pkg::SYNC1));
    assign body_last = (r_body_rem == 16'd1);
    assign word      = {i_rx_byte, r_low_hold};  // header length or body word
    assign id_known  = (r_msg_id == afd_pkg::ID_INFO) || (r_msg_id == afd_pkg::ID_ORIENT) ||
                       (r_msg_id == afd_pkg::ID_PARAM);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                afd_pkg::PH_HEADER, afd_pkg::PH_BADSYNC: begin
                    if (sync_bad) begin
                        n_phase = afd_pkg::PH_BADSYNC;
                    end
                    if (hdr_last) begin
                        if (r_phase == afd_pkg::PH_BADSYNC) begin
                            n_phase = afd_pkg::PH_HALT;
                        end else if (word < afd_pkg::LEN_OVERHEAD) begin
                            n_phase = afd_pkg::PH_HALT;
                        end else if (word != afd_pkg::LEN_OVERHEAD) begin
                            n_phase = afd_pkg::PH_BODY;
                        end else begin
                            n_phase = afd_pkg::PH_HEADER;
                        end
                    end
                end
                afd_pkg::PH_BODY: begin
                    if (body_last) begin
                        n_phase = afd_pkg::PH_HEADER;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Datapath and item classification
    always_comb begin
        n_hdr_pos   = r_hdr_pos;
        n_msg_id    = r_msg_id;
        n_body_rem  = r_body_rem;
        n_body_pos  = r_body_pos;
        n_low_hold  = r_low_hold;
        n_info_seen = r_info_seen;
        o_push      = 1'b0;
        o_job.kind  = afd_pkg::KIND_ORIENT;
        o_job.index = 6'd0;
        o_job.word  = 16'd0;
        o_job.cls   = afd_pkg::SC_RAW;
        o_job.eom   = 1'b0;
        if (accept) begin
            case (r_phase)
                afd_pkg::PH_HEADER, afd_pkg::PH_BADSYNC: begin
                    if (!sync_bad && (r_hdr_pos == 3'd3)) begin
                        n_msg_id = i_rx_byte;
                    end
                    if (!sync_bad && (r_hdr_pos == 3'd4)) begin
                        n_low_hold = i_rx_byte;
                    end
                    n_hdr_pos = hdr_last ? 3'd0 : r_hdr_pos + 3'd1;
                    if (hdr_last) begin
                        if (r_phase == afd_pkg::PH_BADSYNC) begin
                            o_push     = 1'b1;
                            o_job.kind = afd_pkg::KIND_ERROR;
                            o_job.word = afd_pkg::ERR_BAD_SYNC;
                        end else if (word < afd_pkg::LEN_OVERHEAD) begin
                            o_push     = 1'b1;
                            o_job.kind = afd_pkg::KIND_ERROR;
                            o_job.word = afd_pkg::ERR_SHORT_LEN;
                        end else begin
                            n_body_rem = word - afd_pkg::LEN_OVERHEAD;
                            n_body_pos = 16'd0;
                            // empty body: only an unknown id reports
                            if ((word == afd_pkg::LEN_OVERHEAD) && !id_known) begin
                                o_push     = 1'b1;
                                o_job.kind = afd_pkg::KIND_UNKNOWN;
                                o_job.word = {8'd0, r_msg_id};
                                o_job.eom  = 1'b1;
                            end
                        end
                    end
                end
                afd_pkg::PH_BODY: begin
                    n_body_rem = r_body_rem - 16'd1;
                    n_body_pos = r_body_pos + 16'd1;
                    o_job.eom  = body_last;
                    case (r_msg_id)
                        afd_pkg::ID_ORIENT: begin
                            if (!r_body_pos[0]) begin
                                n_low_hold = i_rx_byte;
                            end else if (r_body_pos < afd_pkg::ORIENT_MAIN_END) begin
                                o_push      = 1'b1;
                                o_job.kind  = afd_pkg::KIND_ORIENT;
                                o_job.index = {2'd0, r_body_pos[4:1]};
                                o_job.word  = word;
                                o_job.cls   = afd_pkg::scale_of(r_body_pos[4:1]);
                            end else if (r_body_pos == afd_pkg::ORIENT_TEMP_HI) begin
                                o_push      = 1'b1;
                                o_job.kind  = afd_pkg::KIND_ORIENT;
                                o_job.index = afd_pkg::TEMP_INDEX;
                                o_job.word  = word;
                                o_job.cls   = afd_pkg::SC_TEMP;
                            end
                        end
                        afd_pkg::ID_PARAM: begin
                            if (!r_body_pos[0]) begin
                                n_low_hold = i_rx_byte;
                            end else if (r_body_pos < afd_pkg::PARAM_END) begin
                                o_push      = 1'b1;
                                o_job.kind  = afd_pkg::KIND_PARAM;
                                o_job.index = {5'd0, r_body_pos[1]};
                                o_job.word  = word;
                            end
                        end
                        afd_pkg::ID_INFO: begin
                            if (!r_info_seen && (r_body_pos < afd_pkg::INFO_BYTES)) begin
                                o_push      = 1'b1;
                                o_job.kind  = afd_pkg::KIND_INFO;
                                o_job.index = r_body_pos[5:0];
                                o_job.word  = {8'd0, i_rx_byte};
                                if (r_body_pos == afd_pkg::INFO_LAST) begin
                                    n_info_seen = 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (body_last) begin
                                o_push     = 1'b1;
                                o_job.kind = afd_pkg::KIND_UNKNOWN;
                                o_job.word = {8'd0, r_msg_id};
                            end
                        end
                    endcase
                end
                default: n_hdr_pos = r_hdr_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= afd_pkg::PH_HEADER;
            r_hdr_pos   <= 3'd0;
            r_msg_id    <= 8'd0;
            r_body_rem  <= 16'd0;
            r_body_pos  <= 16'd0;
            r_low_hold  <= 8'd0;
            r_info_seen <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_pos   <= n_hdr_pos;
            r_msg_id    <= n_msg_id;
            r_body_rem  <= n_body_rem;
            r_body_pos  <= n_body_pos;
            r_low_hold  <= n_low_hold;
            r_info_seen <= n_info_seen;
        end
    end

endmodule

// File: rtl/core/afd_queue.sv
module afd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  afd_pkg::t_job i_job,
    input  logic          i_pop,
    output afd_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    afd_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/afd_back.sv
module afd_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_job_valid,
    input  afd_pkg::t_job            i_job,
    input  logic [31:0]              i_accel_scale,
    input  logic [31:0]              i_gyro_scale,
    input  logic                     i_stall,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic [2:0]               o_record_kind,
    output logic [5:0]               o_field_index,
    output logic signed [afd_pkg::VAL_W-1:0] o_field_value,
    output logic                     o_end_of_message
);

    localparam int unsigned PW = afd_pkg::PROD_W;
    localparam int unsigned QW = afd_pkg::Q_W;
    localparam int unsigned VW = afd_pkg::VAL_W;

    logic en;

    // stage 1: magnitude x multiplier + rounding bias
    logic            s1_signed;
    logic            s1_neg;
    logic [16:0]     s1_mag;
    logic [31:0]     s1_mult;
    logic [7:0]      s1_bias;
    logic [PW-1:0]   s1_n;
    afd_pkg::t_meta  s1_meta;
    logic            r1_valid;
    logic [PW-1:0]   r1_n;
    afd_pkg::t_meta  r1_meta;

    // stage 2: reciprocal estimate, shift or pass-through
    logic            s2_div;
    logic [31:0]     s2_recip;
    logic [63:0]     s2_prod;
    logic [QW-1:0]   s2_q;
    logic            r2_valid;
    logic [QW-1:0]   r2_q;
    logic [31:0]     r2_nlow;
    afd_pkg::t_meta  r2_meta;

    // stage 3: remainder correction
    logic            s3_div;
    logic [6:0]      s3_d;
    logic [38:0]     s3_qd;
    logic [31:0]     s3_rem;
    logic [QW-1:0]   s3_q;
    logic            r3_valid;
    logic [QW-1:0]   r3_q;
    afd_pkg::t_meta  r3_meta;

    // stage 4: sign and saturation into the output register
    logic [QW-1:0]   s4_sat;
    logic [VW-1:0]   s4_val;
    logic            r_out_valid;
    afd_pkg::t_meta  r_out_meta;
    logic [VW-1:0]   r_out_val;

    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && i_job_valid;

    always_comb begin
        s1_signed = (i_job.cls != afd_pkg::SC_RAW) && (i_job.cls != afd_pkg::SC_YAW);
        s1_neg    = s1_signed && i_job.word[15];
        s1_mag    = s1_neg ? (17'd0 - {1'b1, i_job.word}) : {1'b0, i_job.word};
        case (i_job.cls)
            afd_pkg::SC_YAW, afd_pkg::SC_ATT: begin
                s1_mult = afd_pkg::MUL_Q16;
                s1_bias = afd_pkg::BIAS_100;
            end
            afd_pkg::SC_TEMP: begin
                s1_mult = afd_pkg::MUL_Q16;
                s1_bias = afd_pkg::BIAS_10;
            end
            afd_pkg::SC_GYRO: begin
                s1_mult = i_gyro_scale;
                s1_bias = afd_pkg::BIAS_SCALE;
            end
            afd_pkg::SC_ACCEL: begin
                s1_mult = i_accel_scale;
                s1_bias = afd_pkg::BIAS_SCALE;
            end
            afd_pkg::SC_MAG: begin
                s1_mult = afd_pkg::MUL_MAG;
                s1_bias = 8'd0;
            end
            default: begin
                s1_mult = afd_pkg::MUL_ONE;
                s1_bias = 8'd0;
            end
        endcase
        s1_n          = PW'(s1_mag) * PW'(s1_mult) + PW'(s1_bias);
        s1_meta.kind  = i_job.kind;
        s1_meta.index = i_job.index;
        s1_meta.cls   = i_job.cls;
        s1_meta.eom   = i_job.eom;
        s1_meta.neg   = s1_neg;
    end

    always_comb begin
        s2_div   = (r1_meta.cls == afd_pkg::SC_YAW) || (r1_meta.cls == afd_pkg::SC_ATT) ||
                   (r1_meta.cls == afd_pkg::SC_TEMP);
        s2_recip = (r1_meta.cls == afd_pkg::SC_TEMP) ? afd_pkg::RECIP_10 : afd_pkg::RECIP_100;
        s2_prod  = 64'(r1_n[31:0]) * 64'(s2_recip);
        if (s2_div) begin
            s2_q = QW'(s2_prod[63:32]);
        end else if ((r1_meta.cls == afd_pkg::SC_GYRO) || (r1_meta.cls == afd_pkg::SC_ACCEL)) begin
            s2_q = r1_n[PW-1:8];
        end else begin
            s2_q = r1_n[QW-1:0];
        end
    end

    always_comb begin
        s3_div = (r2_meta.cls == afd_pkg::SC_YAW) || (r2_meta.cls == afd_pkg::SC_ATT) ||
                 (r2_meta.cls == afd_pkg::SC_TEMP);
        s3_d   = (r2_meta.cls == afd_pkg::SC_TEMP) ? afd_pkg::DIV_10 : afd_pkg::DIV_100;
        s3_qd  = 39'(r2_q[31:0]) * 39'(s3_d);
        s3_rem = r2_nlow - s3_qd[31:0];
        // estimate is low by at most one
        s3_q   = (s3_div && (s3_rem >= 32'(s3_d))) ? r2_q + 1'b1 : r2_q;
    end

    always_comb begin
        if (r3_meta.neg) begin
            s4_sat = (r3_q > afd_pkg::NEG_LIMIT) ? afd_pkg::NEG_LIMIT : r3_q;
            s4_val = VW'(QW'(0) - s4_sat);
        end else begin
            s4_sat = (r3_q > afd_pkg::POS_LIMIT) ? afd_pkg::POS_LIMIT : r3_q;
            s4_val = s4_sat[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_n      <= s1_n;
            r1_meta   <= s1_meta;
            r2_q      <= s2_q;
            r2_nlow   <= r1_n[31:0];
            r2_meta   <= r1_meta;
            r3_q      <= s3_q;
            r3_meta   <= r2_meta;
            r_out_val <= s4_val;
            r_out_meta <= r3_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_job_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_record_kind    = r_out_meta.kind;
    assign o_field_index    = r_out_meta.index;
    assign o_field_value    = signed'(r_out_val);
    assign o_end_of_message = r_out_meta.eom;

endmodule

// File: rtl/core/ahrs_frame_deframer_top.sv
// A result passes the queue, r1, r2 and r3 to the output register. Bytes: one per cycle
//   unless o_stall; results drain one per cycle unless i_stall, via a four-stage
//   scaling pipeline (multiply, reciprocal estimate, remainder fix, sign/saturate).
// Reset (i_rst_n, synchronous, active low): parser to header search, queue and pipeline
//   emptied, both scale registers back to 1.0 (Q8.24).
module ahrs_frame_deframer_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // byte input
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [7:0]                           i_rx_byte,
    // record output
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [2:0]                           o_record_kind,
    output logic [5:0]                           o_field_index,
    output logic signed [afd_pkg::VAL_W-1:0]     o_field_value,
    output logic                                 o_end_of_message,
    // config writes
    input  logic                                 i_cfg_we,
    input  logic [afd_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    // Scale registers, Q8.24 reciprocals of sensor gain. The user must write them
    // only while idle, so the back end can read them live; the block does not enforce it.
    logic [31:0] r_accel_scale;
    logic [31:0] r_gyro_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_scale <= afd_pkg::SCALE_RESET;
            r_gyro_scale  <= afd_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            // unknown indexes are dropped
            if (i_cfg_index == afd_pkg::CFG_ACCEL_SCALE) begin
                r_accel_scale <= i_cfg_data;
            end
            if (i_cfg_index == afd_pkg::CFG_GYRO_SCALE) begin
                r_gyro_scale <= i_cfg_data;
            end
        end
    end

    // Front: header/body parser. Each accepted byte updates the frame state
    // and, when it completes a field, pushes one classified item.
    logic          push;
    logic          q_full;
    logic          q_empty;
    logic          pop;
    afd_pkg::t_job front_job;
    afd_pkg::t_job queue_job;

    afd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_full    (q_full),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_job     (front_job)
    );

    // Short queue decouples the parser from output back-pressure;
    // the parser stalls only once it fills.
    afd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: scaling pipeline ending in the output register. Whole pipe holds
    // while a finished item waits on i_stall.
    afd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (!q_empty),
        .i_job            (queue_job),
        .i_accel_scale    (r_accel_scale),
        .i_gyro_scale     (r_gyro_scale),
        .i_stall          (i_stall),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_record_kind    (o_record_kind),
        .o_field_index    (o_field_index),
        .o_field_value    (o_field_value),
        .o_end_of_message (o_end_of_message)
    );

endmodule
